// ===== design/hcmn_pkg.sv =====
`default_nettype none

package hcmn_pkg;

    // grid and field widths
    localparam int GRID_MAX_DEF = 1024;
    localparam int H_W          = 24;
    localparam int SP_W         = 23;
    localparam int HOLE_W       = 11;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 23;
    localparam int NXZ_W        = 16;
    localparam int NY_W         = 15;

    // normal datapath widths
    localparam int PROD_W     = 48;
    localparam int MAG_W      = 47;
    localparam int POS_W      = 6;
    localparam int NM_W       = 30;
    localparam int NORM_MSB   = 29;
    localparam int SQR_W      = 60;
    localparam int SQ_W       = 63;
    localparam int SQRT_STEPS = 32;
    localparam int LEN_W      = 31;
    localparam int Q_W        = 15;
    localparam int FRAC_BITS  = 14;
    localparam int REM_W      = 46;
    localparam int ONE_Q14    = 16384;

    // result buffer
    localparam int SLOT_DEPTH = 16;
    localparam int SLOT_AW    = 4;

    // vertex sequence
    localparam int PH_W    = 3;
    localparam int PH_LAST = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_H_SPACING   = 4'd0,
        REG_V_SPACING   = 4'd1,
        REG_HALF_WIDTH  = 4'd2,
        REG_HALF_HEIGHT = 4'd3,
        REG_HOLE_COL_LO = 4'd4,
        REG_HOLE_COL_HI = 4'd5,
        REG_HOLE_ROW_LO = 4'd6,
        REG_HOLE_ROW_HI = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [NXZ_W-1:0] x;
        logic        [NY_W-1:0]  y;
        logic signed [NXZ_W-1:0] z;
    } normal_t;

    typedef struct packed {
        logic [SP_W-1:0] h_spacing;
        logic [SP_W-1:0] v_spacing;
        logic [SP_W-1:0] half_width;
        logic [SP_W-1:0] half_height;
    } geom_t;

    typedef struct packed {
        logic signed [H_W-1:0] a;
        logic signed [H_W-1:0] b;
        logic signed [H_W-1:0] c;
        logic signed [H_W-1:0] d;
    } heights_t;

endpackage

`default_nettype wire

// ===== design/hcmn_normal.sv =====
`default_nettype none

module hcmn_normal
    import hcmn_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic signed [PROD_W-1:0] c0,
    input  wire logic signed [PROD_W-1:0] c1,
    input  wire logic signed [PROD_W-1:0] c2,
    output logic                          out_valid,
    output normal_t                       out_norm
);

    logic signed [PROD_W-1:0] c_in [3];

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0]           sg1_reg, sg2_reg, sg3_reg, sg4_reg;
    logic [MAG_W-1:0]     m1_reg [3];
    logic [MAG_W-1:0]     m2_reg [3];
    logic [POS_W-1:0]     pos2_reg;
    logic                 z2_reg, z3_reg, z4_reg;
    logic [NM_W-1:0]      m3_reg [3];
    logic [NM_W-1:0]      m4_reg [3];
    logic [SQR_W-1:0]     sqr4_reg [3];

    logic                 sq_v_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0]      sq_s_reg [SQRT_STEPS+1];
    logic [SQ_W-1:0]      sq_r_reg [SQRT_STEPS+1];
    logic [NM_W-1:0]      sq_m_reg [SQRT_STEPS+1][3];
    logic [2:0]           sq_sg_reg [SQRT_STEPS+1];
    logic                 sq_z_reg [SQRT_STEPS+1];

    logic                 dv_v_reg [Q_W+1];
    logic [REM_W-1:0]     dv_rem_reg [Q_W+1][3];
    logic [Q_W-1:0]       dv_q_reg [Q_W+1][3];
    logic [LEN_W-1:0]     dv_len_reg [Q_W+1];
    logic [2:0]           dv_sg_reg [Q_W+1];
    logic                 dv_z_reg [Q_W+1];

    logic                 out_v_reg;
    normal_t              out_n_reg;

    logic [MAG_W-1:0]     mag_next [3];
    logic [MAG_W-1:0]     or_mag;
    logic [POS_W-1:0]     pos_next;
    logic [MAG_W-1:0]     sh_tmp [3];
    logic [SQ_W-1:0]      sum_next;
    logic [LEN_W-1:0]     len_fin;
    logic [REM_W-1:0]     rem_init [3];
    logic [Q_W-1:0]       q_clamp [3];
    normal_t              norm_next;

    assign c_in[0] = c0;
    assign c_in[1] = c1;
    assign c_in[2] = c2;

    // magnitudes
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (c_in[k][PROD_W-1])
                mag_next[k] = MAG_W'(-c_in[k]);
            else
                mag_next[k] = MAG_W'(c_in[k]);
        end
    end

    // leading one of the largest magnitude, same as that of the or of all three
    always_comb
    begin
        or_mag   = m1_reg[0] | m1_reg[1] | m1_reg[2];
        pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (or_mag[i])
                pos_next = POS_W'(i);
        end
    end

    // common shift so the largest lands in [2^29, 2^30)
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (pos2_reg >= POS_W'(NORM_MSB))
                sh_tmp[k] = m2_reg[k] >> (pos2_reg - POS_W'(NORM_MSB));
            else
                sh_tmp[k] = m2_reg[k] << (POS_W'(NORM_MSB) - pos2_reg);
        end
    end

    assign sum_next = SQ_W'(sqr4_reg[0]) + SQ_W'(sqr4_reg[1]) + SQ_W'(sqr4_reg[2]);

    // front stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            sq_v_reg[0] <= v4_reg;
        end
    end

    // front stage data
    always_ff @(posedge clk)
    begin
        sg1_reg  <= {c_in[2][PROD_W-1], c_in[1][PROD_W-1], c_in[0][PROD_W-1]};
        sg2_reg  <= sg1_reg;
        sg3_reg  <= sg2_reg;
        sg4_reg  <= sg3_reg;
        pos2_reg <= pos_next;
        z2_reg   <= (or_mag == '0);
        z3_reg   <= z2_reg;
        z4_reg   <= z3_reg;
        for (int k = 0; k < 3; k++)
        begin
            m1_reg[k]   <= mag_next[k];
            m2_reg[k]   <= m1_reg[k];
            m3_reg[k]   <= sh_tmp[k][NM_W-1:0];
            m4_reg[k]   <= m3_reg[k];
            sqr4_reg[k] <= m3_reg[k] * m3_reg[k];
            sq_m_reg[0][k] <= m4_reg[k];
        end
        sq_s_reg[0]  <= sum_next;
        sq_r_reg[0]  <= '0;
        sq_sg_reg[0] <= sg4_reg;
        sq_z_reg[0]  <= z4_reg;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [SQ_W-1:0] bit_w, trial, s_next, r_next;

        always_comb
        begin
            bit_w = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            trial = sq_r_reg[k] + bit_w;
            if (sq_s_reg[k] >= trial)
            begin
                s_next = sq_s_reg[k] - trial;
                r_next = (sq_r_reg[k] >> 1) + bit_w;
            end
            else
            begin
                s_next = sq_s_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_s_reg[k+1]  <= s_next;
            sq_r_reg[k+1]  <= r_next;
            sq_sg_reg[k+1] <= sq_sg_reg[k];
            sq_z_reg[k+1]  <= sq_z_reg[k];
            for (int j = 0; j < 3; j++)
                sq_m_reg[k+1][j] <= sq_m_reg[k][j];
        end
    end

    // dividend with rounding half of the length
    always_comb
    begin
        len_fin = sq_r_reg[SQRT_STEPS][LEN_W-1:0];
        for (int k = 0; k < 3; k++)
            rem_init[k] = (REM_W'(sq_m_reg[SQRT_STEPS][k]) << FRAC_BITS)
                        + REM_W'(len_fin >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else
            dv_v_reg[0] <= sq_v_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        dv_len_reg[0] <= len_fin;
        dv_sg_reg[0]  <= sq_sg_reg[SQRT_STEPS];
        dv_z_reg[0]   <= sq_z_reg[SQRT_STEPS];
        for (int k = 0; k < 3; k++)
        begin
            dv_rem_reg[0][k] <= rem_init[k];
            dv_q_reg[0][k]   <= '0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        logic [REM_W-1:0] dsub;
        logic [REM_W-1:0] rem_next [3];
        logic [Q_W-1:0]   q_next [3];

        always_comb
        begin
            dsub = REM_W'(dv_len_reg[j]) << (Q_W - 1 - j);
            for (int k = 0; k < 3; k++)
            begin
                if (dv_rem_reg[j][k] >= dsub)
                begin
                    rem_next[k] = dv_rem_reg[j][k] - dsub;
                    q_next[k]   = dv_q_reg[j][k] | (Q_W'(1) << (Q_W - 1 - j));
                end
                else
                begin
                    rem_next[k] = dv_rem_reg[j][k];
                    q_next[k]   = dv_q_reg[j][k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            dv_len_reg[j+1] <= dv_len_reg[j];
            dv_sg_reg[j+1]  <= dv_sg_reg[j];
            dv_z_reg[j+1]   <= dv_z_reg[j];
            for (int k = 0; k < 3; k++)
            begin
                dv_rem_reg[j+1][k] <= rem_next[k];
                dv_q_reg[j+1][k]   <= q_next[k];
            end
        end
    end

    // clamp, sign and the zero vector case
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv_q_reg[Q_W][k] > Q_W'(ONE_Q14))
                q_clamp[k] = Q_W'(ONE_Q14);
            else
                q_clamp[k] = dv_q_reg[Q_W][k];
        end
        if (dv_z_reg[Q_W])
        begin
            norm_next.x = '0;
            norm_next.y = NY_W'(ONE_Q14);
            norm_next.z = '0;
        end
        else
        begin
            norm_next.x = dv_sg_reg[Q_W][0] ? -NXZ_W'(q_clamp[0]) : NXZ_W'(q_clamp[0]);
            norm_next.y = q_clamp[1];
            norm_next.z = dv_sg_reg[Q_W][2] ? -NXZ_W'(q_clamp[2]) : NXZ_W'(q_clamp[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= dv_v_reg[Q_W];
    end

    always_ff @(posedge clk)
    begin
        out_n_reg <= norm_next;
    end

    assign out_valid = out_v_reg;
    assign out_norm  = out_n_reg;

endmodule

`default_nettype wire

// ===== design/hcmn_vbuf.sv =====
`default_nettype none

module hcmn_vbuf
    import hcmn_pkg::*;
#(
    parameter int CW = 10
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire geom_t                   geom,
    input  wire logic                    alloc,
    input  wire logic [CW-1:0]           alloc_col,
    input  wire logic [CW-1:0]           alloc_row,
    input  wire heights_t                alloc_hts,
    input  wire logic                    nrm_valid,
    input  wire normal_t                 nrm1,
    input  wire normal_t                 nrm2,
    output logic                         full,
    output logic                         vertex_valid,
    output logic signed [H_W-1:0]        pos_x,
    output logic signed [H_W-1:0]        pos_y,
    output logic signed [H_W-1:0]        pos_z,
    output logic signed [NXZ_W-1:0]      norm_x,
    output logic [NY_W-1:0]              norm_y,
    output logic signed [NXZ_W-1:0]      norm_z,
    output logic                         last_vertex
);

    localparam int RAW_W = CW + SP_W + 3;

    // slot storage
    logic [CW-1:0]  col_mem [SLOT_DEPTH];
    logic [CW-1:0]  row_mem [SLOT_DEPTH];
    heights_t       hts_mem [SLOT_DEPTH];
    normal_t        n1_mem  [SLOT_DEPTH];
    normal_t        n2_mem  [SLOT_DEPTH];

    logic [SLOT_AW-1:0] wr_ptr_reg, ex_ptr_reg, rd_ptr_reg;
    logic [SLOT_AW:0]   count_reg, count_next;
    logic [SLOT_DEPTH-1:0] done_reg, done_next;

    logic           f_v_reg, p_v_reg, e_act_reg;
    logic [CW-1:0]  f_col_reg, f_row_reg;
    heights_t       f_hts_reg, p_hts_reg, e_hts_reg;
    normal_t        f_n1_reg, f_n2_reg, p_n1_reg, p_n2_reg, e_n1_reg, e_n2_reg;
    logic signed [H_W-1:0] p_x0_reg, p_x1_reg, p_z0_reg, p_z1_reg;
    logic signed [H_W-1:0] e_x0_reg, e_x1_reg, e_z0_reg, e_z1_reg;
    logic [PH_W-1:0] e_ph_reg;

    logic f_load, p_load, e_take, e_end;
    logic [RAW_W-1:0] px_prod, pz_prod;
    logic signed [RAW_W-1:0] rx0, rx1, rz0, rz1;

    function automatic logic signed [H_W-1:0] sat24(input logic signed [RAW_W-1:0] v);
        logic signed [H_W-1:0] r;
        if (v[RAW_W-1:H_W-1] == '0 || v[RAW_W-1:H_W-1] == '1)
            r = v[H_W-1:0];
        else if (v[RAW_W-1])
            r = {1'b1, {(H_W-1){1'b0}}};
        else
            r = {1'b0, {(H_W-1){1'b1}}};
        return r;
    endfunction

    // handshakes between fetch, position and emit stages
    assign e_end  = e_act_reg && (e_ph_reg == PH_W'(PH_LAST));
    assign e_take = p_v_reg && (!e_act_reg || e_end);
    assign p_load = f_v_reg && (!p_v_reg || e_take);
    assign f_load = done_reg[rd_ptr_reg] && (!f_v_reg || p_load);
    assign full   = (count_reg == (SLOT_AW+1)'(SLOT_DEPTH));

    // slot bookkeeping
    always_comb
    begin
        count_next = count_reg + (SLOT_AW+1)'(alloc) - (SLOT_AW+1)'(f_load);
        done_next  = done_reg;
        if (nrm_valid)
            done_next[ex_ptr_reg] = 1'b1;
        if (f_load)
            done_next[rd_ptr_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            ex_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
            f_v_reg    <= 1'b0;
            p_v_reg    <= 1'b0;
            e_act_reg  <= 1'b0;
            e_ph_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            if (alloc)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (nrm_valid)
                ex_ptr_reg <= ex_ptr_reg + 1'b1;
            if (f_load)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (f_load)
                f_v_reg <= 1'b1;
            else if (p_load)
                f_v_reg <= 1'b0;
            if (p_load)
                p_v_reg <= 1'b1;
            else if (e_take)
                p_v_reg <= 1'b0;
            if (e_take)
            begin
                e_act_reg <= 1'b1;
                e_ph_reg  <= '0;
            end
            else if (e_end)
                e_act_reg <= 1'b0;
            else if (e_act_reg)
                e_ph_reg <= e_ph_reg + 1'b1;
        end
    end

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            col_mem[wr_ptr_reg] <= alloc_col;
            row_mem[wr_ptr_reg] <= alloc_row;
            hts_mem[wr_ptr_reg] <= alloc_hts;
        end
        if (nrm_valid)
        begin
            n1_mem[ex_ptr_reg] <= nrm1;
            n2_mem[ex_ptr_reg] <= nrm2;
        end
        if (f_load)
        begin
            f_col_reg <= col_mem[rd_ptr_reg];
            f_row_reg <= row_mem[rd_ptr_reg];
            f_hts_reg <= hts_mem[rd_ptr_reg];
            f_n1_reg  <= n1_mem[rd_ptr_reg];
            f_n2_reg  <= n2_mem[rd_ptr_reg];
        end
    end

    // corner coordinates before saturation
    always_comb
    begin
        px_prod = f_col_reg * geom.h_spacing;
        pz_prod = f_row_reg * geom.v_spacing;
        rx0 = $signed(px_prod) - $signed(RAW_W'(geom.half_width));
        rx1 = rx0 + $signed(RAW_W'(geom.h_spacing));
        rz0 = $signed(pz_prod) - $signed(RAW_W'(geom.half_height));
        rz1 = rz0 + $signed(RAW_W'(geom.v_spacing));
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            p_x0_reg  <= sat24(rx0);
            p_x1_reg  <= sat24(rx1);
            p_z0_reg  <= sat24(rz0);
            p_z1_reg  <= sat24(rz1);
            p_hts_reg <= f_hts_reg;
            p_n1_reg  <= f_n1_reg;
            p_n2_reg  <= f_n2_reg;
        end
        if (e_take)
        begin
            e_x0_reg  <= p_x0_reg;
            e_x1_reg  <= p_x1_reg;
            e_z0_reg  <= p_z0_reg;
            e_z1_reg  <= p_z1_reg;
            e_hts_reg <= p_hts_reg;
            e_n1_reg  <= p_n1_reg;
            e_n2_reg  <= p_n2_reg;
        end
    end

    // vertex order a b c, c b d
    always_comb
    begin
        vertex_valid = e_act_reg;
        last_vertex  = e_end;
        case (e_ph_reg)
            3'd0:
            begin
                pos_x = e_x0_reg; pos_z = e_z0_reg; pos_y = e_hts_reg.a;
                {norm_x, norm_y, norm_z} = e_n1_reg;
            end
            3'd1:
            begin
                pos_x = e_x0_reg; pos_z = e_z1_reg; pos_y = e_hts_reg.b;
                {norm_x, norm_y, norm_z} = e_n1_reg;
            end
            3'd2:
            begin
                pos_x = e_x1_reg; pos_z = e_z0_reg; pos_y = e_hts_reg.c;
                {norm_x, norm_y, norm_z} = e_n1_reg;
            end
            3'd3:
            begin
                pos_x = e_x1_reg; pos_z = e_z0_reg; pos_y = e_hts_reg.c;
                {norm_x, norm_y, norm_z} = e_n2_reg;
            end
            3'd4:
            begin
                pos_x = e_x0_reg; pos_z = e_z1_reg; pos_y = e_hts_reg.b;
                {norm_x, norm_y, norm_z} = e_n2_reg;
            end
            default:
            begin
                pos_x = e_x1_reg; pos_z = e_z1_reg; pos_y = e_hts_reg.d;
                {norm_x, norm_y, norm_z} = e_n2_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/heightmap_cell_mesh_normals_unit.sv =====
`default_nettype none

// Heightmap cell mesher. A cell is taken when start is high and busy is low; a cell
// inside the hole box or outside the grid is taken and dropped. Every other cell
// yields six vertices, triangles (a, b, c) then (c, b, d), on consecutive cycles
// marked by vertex_valid, with last_vertex on the sixth; the receiver cannot stall
// them. While busy is low, cells may enter one per cycle into the normal pipeline
// (58 stages: cross products, normalising shift, a 32-stage square root and a
// 15-stage divider); the sixteen-slot result buffer holds cells until the single
// vertex port can emit them, so sustained throughput is set by that port. busy
// rises while sixteen cells are held. Configuration is accepted every cycle
// (cfg_ready is always high) and must only change while no cell is in flight.

module heightmap_cell_mesh_normals_unit
    import hcmn_pkg::*;
#(
    parameter int GRID_MAX = GRID_MAX_DEF,
    parameter int CW       = $clog2(GRID_MAX)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CW-1:0]           cell_col,
    input  wire logic [CW-1:0]           cell_row,
    input  wire logic signed [H_W-1:0]   height_corner_a,
    input  wire logic signed [H_W-1:0]   height_corner_b,
    input  wire logic signed [H_W-1:0]   height_corner_c,
    input  wire logic signed [H_W-1:0]   height_corner_d,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    output logic                         vertex_valid,
    output logic signed [H_W-1:0]        pos_x,
    output logic signed [H_W-1:0]        pos_y,
    output logic signed [H_W-1:0]        pos_z,
    output logic signed [NXZ_W-1:0]      norm_x,
    output logic [NY_W-1:0]              norm_y,
    output logic signed [NXZ_W-1:0]      norm_z,
    output logic                         last_vertex
);

    localparam int CMP_W = ((CW + 2) > (HOLE_W + 1)) ? (CW + 2) : (HOLE_W + 1);
    localparam int DIF_W = H_W + 1;

    geom_t              geom_reg;
    logic [HOLE_W-1:0]  col_lo_reg, col_hi_reg, row_lo_reg, row_hi_reg;

    logic               accept, keep, in_grid, in_hole;
    logic               full;
    heights_t           hts_in;

    logic               s0_v_reg, s1_v_reg, s2_v_reg, s3_v_reg;
    heights_t           s0_h_reg;
    logic signed [DIF_W-1:0] d_ca_reg, d_ba_reg, d_db_reg, d_dc_reg;
    logic signed [PROD_W-1:0] a0_reg, a2_reg, b0_reg, b2_reg;
    logic [PROD_W-1:0]  hv_reg;
    logic signed [PROD_W-1:0] t1c0_reg, t1c1_reg, t1c2_reg;
    logic signed [PROD_W-1:0] t2c0_reg, t2c1_reg, t2c2_reg;
    logic               flip;

    logic               nv1, nv2;
    normal_t            n1, n2;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.h_spacing   <= SP_W'(4096);
            geom_reg.v_spacing   <= SP_W'(4096);
            geom_reg.half_width  <= '0;
            geom_reg.half_height <= '0;
            col_lo_reg <= '0;
            col_hi_reg <= '0;
            row_lo_reg <= '0;
            row_hi_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_H_SPACING:   geom_reg.h_spacing   <= cfg_data[SP_W-1:0];
                REG_V_SPACING:   geom_reg.v_spacing   <= cfg_data[SP_W-1:0];
                REG_HALF_WIDTH:  geom_reg.half_width  <= cfg_data[SP_W-1:0];
                REG_HALF_HEIGHT: geom_reg.half_height <= cfg_data[SP_W-1:0];
                REG_HOLE_COL_LO: col_lo_reg <= cfg_data[HOLE_W-1:0];
                REG_HOLE_COL_HI: col_hi_reg <= cfg_data[HOLE_W-1:0];
                REG_HOLE_ROW_LO: row_lo_reg <= cfg_data[HOLE_W-1:0];
                REG_HOLE_ROW_HI: row_hi_reg <= cfg_data[HOLE_W-1:0];
                default: ;
            endcase
        end
    end

    // cell intake and hole test
    assign busy    = full;
    assign accept  = start && !busy;
    assign in_grid = (CMP_W'(cell_col) < CMP_W'(GRID_MAX)) &&
                     (CMP_W'(cell_row) < CMP_W'(GRID_MAX));
    assign in_hole = (CMP_W'(cell_col) >= CMP_W'(col_lo_reg)) &&
                     (CMP_W'(cell_col) <  CMP_W'(col_hi_reg)) &&
                     (CMP_W'(cell_row) >= CMP_W'(row_lo_reg)) &&
                     (CMP_W'(cell_row) <  CMP_W'(row_hi_reg));
    assign keep    = accept && in_grid && !in_hole;

    assign hts_in.a = height_corner_a;
    assign hts_in.b = height_corner_b;
    assign hts_in.c = height_corner_c;
    assign hts_in.d = height_corner_d;

    // cross product: flip when the y part, minus hs times vs, is negative
    assign flip = (hv_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= keep;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_h_reg <= hts_in;
        d_ca_reg <= DIF_W'(s0_h_reg.c) - DIF_W'(s0_h_reg.a);
        d_ba_reg <= DIF_W'(s0_h_reg.b) - DIF_W'(s0_h_reg.a);
        d_db_reg <= DIF_W'(s0_h_reg.d) - DIF_W'(s0_h_reg.b);
        d_dc_reg <= DIF_W'(s0_h_reg.d) - DIF_W'(s0_h_reg.c);
        a0_reg   <= $signed({1'b0, geom_reg.v_spacing}) * d_ca_reg;
        a2_reg   <= $signed({1'b0, geom_reg.h_spacing}) * d_ba_reg;
        b0_reg   <= $signed({1'b0, geom_reg.v_spacing}) * d_db_reg;
        b2_reg   <= $signed({1'b0, geom_reg.h_spacing}) * d_dc_reg;
        hv_reg   <= geom_reg.h_spacing * geom_reg.v_spacing;
        t1c0_reg <= flip ? -a0_reg : a0_reg;
        t1c1_reg <= flip ? $signed(hv_reg) : '0;
        t1c2_reg <= flip ? -a2_reg : a2_reg;
        t2c0_reg <= flip ? -b0_reg : b0_reg;
        t2c1_reg <= flip ? $signed(hv_reg) : '0;
        t2c2_reg <= flip ? -b2_reg : b2_reg;
    end

    // unit normals of both triangles
    hcmn_normal u_norm1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .c0        (t1c0_reg),
        .c1        (t1c1_reg),
        .c2        (t1c2_reg),
        .out_valid (nv1),
        .out_norm  (n1)
    );

    hcmn_normal u_norm2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .c0        (t2c0_reg),
        .c1        (t2c1_reg),
        .c2        (t2c2_reg),
        .out_valid (nv2),
        .out_norm  (n2)
    );

    // result buffer and vertex sequencer
    hcmn_vbuf #(
        .CW (CW)
    ) u_vbuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom_reg),
        .alloc        (keep),
        .alloc_col    (cell_col),
        .alloc_row    (cell_row),
        .alloc_hts    (hts_in),
        .nrm_valid    (nv1),
        .nrm1         (n1),
        .nrm2         (n2),
        .full         (full),
        .vertex_valid (vertex_valid),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .norm_z       (norm_z),
        .last_vertex  (last_vertex)
    );

    // both normal pipelines stay in lock step
    a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        nv1 == nv2)
        else $error("normal pipelines out of step");

    // a cell's vertices come on consecutive cycles
    a_vertex_run: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !last_vertex |=> vertex_valid)
        else $error("vertex run broken");

    // the x and y parts of a normal never exceed unit length
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> (norm_y <= NY_W'(ONE_Q14)) &&
                         (norm_x <= ONE_Q14) && (norm_x >= -ONE_Q14))
        else $error("normal out of range");

endmodule

`default_nettype wire

// ===== verif/heightmap_cell_mesh_normals_unit_tb.sv =====
`timescale 1ns / 1ps

module heightmap_cell_mesh_normals_unit_tb;
    import hcmn_pkg::*;

    // register indexes past the end of the map, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd9;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic signed [H_W-1:0]   x;
        logic signed [H_W-1:0]   y;
        logic signed [H_W-1:0]   z;
        logic signed [NXZ_W-1:0] nx;
        logic        [NY_W-1:0]  ny;
        logic signed [NXZ_W-1:0] nz;
        logic                    last;
    } vertex_t;

    // mesh scoreboard: register copy, vertex prediction and comparison
    class mesh_scoreboard;
        logic [SP_W-1:0]   h_sp, v_sp, half_w, half_h;
        logic [HOLE_W-1:0] col_lo, col_hi, row_lo, row_hi;
        vertex_t           expected_vertices[$];
        int                errors;

        function new();
            h_sp = 23'd4096;
            v_sp = 23'd4096;
            half_w = '0;
            half_h = '0;
            col_lo = '0;
            col_hi = '0;
            row_lo = '0;
            row_hi = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_H_SPACING:   h_sp = data;
                REG_V_SPACING:   v_sp = data;
                REG_HALF_WIDTH:  half_w = data;
                REG_HALF_HEIGHT: half_h = data;
                REG_HOLE_COL_LO: col_lo = data[HOLE_W-1:0];
                REG_HOLE_COL_HI: col_hi = data[HOLE_W-1:0];
                REG_HOLE_ROW_LO: row_lo = data[HOLE_W-1:0];
                REG_HOLE_ROW_HI: row_hi = data[HOLE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sat24(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s)
                b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // unit normal of u x w, flipped to non-negative y, Q1.14
        function void unit_normal(input longint u0, u1, u2, w0, w1, w2,
                                  output int n0, n1, n2);
            longint          c[3];
            longint unsigned m[3];
            longint unsigned mx, s, len, q;
            int              k;
            int              n[3];
            c[0] = u1 * w2 - u2 * w1;
            c[1] = u2 * w0 - u0 * w2;
            c[2] = u0 * w1 - u1 * w0;
            if (c[1] < 0)
            begin
                for (k = 0; k < 3; k++)
                    c[k] = -c[k];
            end
            mx = 0;
            for (k = 0; k < 3; k++)
            begin
                m[k] = (c[k] < 0) ? -c[k] : c[k];
                if (m[k] > mx)
                    mx = m[k];
            end
            if (mx == 0)
            begin
                n0 = 0;
                n1 = ONE_Q14;
                n2 = 0;
                return;
            end
            // normalise so the largest part sits in [2^29, 2^30)
            while (mx >= (64'd1 << 30))
            begin
                mx = mx >> 1;
                for (k = 0; k < 3; k++)
                    m[k] = m[k] >> 1;
            end
            while (mx < (64'd1 << 29))
            begin
                mx = mx << 1;
                for (k = 0; k < 3; k++)
                    m[k] = m[k] << 1;
            end
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            len = int_sqrt(s);
            for (k = 0; k < 3; k++)
            begin
                q = ((m[k] << 14) + (len >> 1)) / len;
                if (q > ONE_Q14)
                    q = ONE_Q14;
                n[k] = (c[k] < 0) ? -int'(q) : int'(q);
            end
            n0 = n[0];
            n1 = n[1];
            n2 = n[2];
        endfunction

        // accepted cell: queue its six vertices unless it falls in the hole or outside the grid
        function void note_cell(int col, int row, logic signed [H_W-1:0] ha, hb, hc, hd);
            longint  h[4], px[4], pz[4];
            longint  hs, vs;
            int      t1[3], t2[3];
            int      corner_of[6];
            int      k, cn;
            vertex_t v;
            if (col >= GRID_MAX_DEF || row >= GRID_MAX_DEF)
                return;
            if (col >= col_lo && col < col_hi && row >= row_lo && row < row_hi)
                return;
            corner_of = '{0, 1, 2, 2, 1, 3};
            h[0] = ha;
            h[1] = hb;
            h[2] = hc;
            h[3] = hd;
            hs = h_sp;
            vs = v_sp;
            for (k = 0; k < 4; k++)
            begin
                px[k] = sat24((col + ((k >> 1) & 1)) * hs - longint'(half_w));
                pz[k] = sat24((row + (k & 1)) * vs - longint'(half_h));
            end
            unit_normal(0, h[0] - h[1], -vs, hs, h[2] - h[1], -vs, t1[0], t1[1], t1[2]);
            unit_normal(hs, h[2] - h[1], -vs, hs, h[3] - h[1], 0, t2[0], t2[1], t2[2]);
            for (k = 0; k < 6; k++)
            begin
                cn = corner_of[k];
                v.x = px[cn];
                v.y = h[cn];
                v.z = pz[cn];
                v.nx = (k < 3) ? t1[0] : t2[0];
                v.ny = (k < 3) ? t1[1] : t2[1];
                v.nz = (k < 3) ? t1[2] : t2[2];
                v.last = (k == 5);
                expected_vertices.insert(expected_vertices.size(), v);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_vertex(vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                report("unexpected vertex, pos_x", got.x, 0);
                return;
            end
            want = expected_vertices.pop_front();
            if (got.x !== want.x)    report("pos_x", got.x, want.x);
            if (got.y !== want.y)    report("pos_y", got.y, want.y);
            if (got.z !== want.z)    report("pos_z", got.z, want.z);
            if (got.nx !== want.nx)  report("norm_x", got.nx, want.nx);
            if (got.ny !== want.ny)  report("norm_y", got.ny, want.ny);
            if (got.nz !== want.nz)  report("norm_z", got.nz, want.nz);
            if (got.last !== want.last) report("last_vertex", got.last, want.last);
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [9:0]              cell_col;
    logic [9:0]              cell_row;
    logic signed [H_W-1:0]   height_corner_a;
    logic signed [H_W-1:0]   height_corner_b;
    logic signed [H_W-1:0]   height_corner_c;
    logic signed [H_W-1:0]   height_corner_d;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    vertex_valid;
    logic signed [H_W-1:0]   pos_x;
    logic signed [H_W-1:0]   pos_y;
    logic signed [H_W-1:0]   pos_z;
    logic signed [NXZ_W-1:0] norm_x;
    logic [NY_W-1:0]         norm_y;
    logic signed [NXZ_W-1:0] norm_z;
    logic                    last_vertex;

    mesh_scoreboard sb;

    heightmap_cell_mesh_normals_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cell_col        (cell_col),
        .cell_row        (cell_row),
        .height_corner_a (height_corner_a),
        .height_corner_b (height_corner_b),
        .height_corner_c (height_corner_c),
        .height_corner_d (height_corner_d),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .vertex_valid    (vertex_valid),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .norm_x          (norm_x),
        .norm_y          (norm_y),
        .norm_z          (norm_z),
        .last_vertex     (last_vertex)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // vertex monitor, one word per strobe
    always @(posedge clk)
    begin
        vertex_t got;
        if (rst_n && vertex_valid)
        begin
            got.x = pos_x;
            got.y = pos_y;
            got.z = pos_z;
            got.nx = norm_x;
            got.ny = norm_y;
            got.nz = norm_z;
            got.last = last_vertex;
            sb.check_vertex(got);
        end
    end

    // register write, valid left high for a following write
    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task end_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // cell word, start left high for a following cell
    task send_cell(int col, int row, logic signed [H_W-1:0] ha, hb, hc, hd);
        start <= 1'b1;
        cell_col <= col;
        cell_row <= row;
        height_corner_a <= ha;
        height_corner_b <= hb;
        height_corner_c <= hc;
        height_corner_d <= hd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_cell(col, row, ha, hb, hc, hd);
    endtask

    task pause(int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // wait for every vertex, then let dropped cells clear the pipeline
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function logic signed [H_W-1:0] rand_height();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed(24'($urandom_range(0, 16383))) - 24'sd8192;
            default: return $signed(24'($urandom_range(0, 1048575))) - 24'sd524288;
        endcase
    endfunction

    task random_cells(int count, int span);
        int n, burst, col, row;
        logic signed [H_W-1:0] base;
        burst = 0;
        for (n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    burst = $urandom_range(16, 40);
                else
                    burst = $urandom_range(1, 8);
                if ($urandom_range(0, 2) != 0)
                    pause($urandom_range(1, 14));
            end
            burst--;
            if ($urandom_range(0, 4) == 0)
            begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end
            else
            begin
                col = $urandom_range(0, span);
                row = $urandom_range(0, span);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                // gentle terrain around one base height
                base = rand_height();
                send_cell(col, row, base, base + $signed(24'($urandom_range(0, 8191))) - 4096,
                          base + $signed(24'($urandom_range(0, 8191))) - 4096,
                          base + $signed(24'($urandom_range(0, 8191))) - 4096);
            end
            else
                send_cell(col, row, rand_height(), rand_height(), rand_height(), rand_height());
        end
    endtask

    task random_config();
        int lo_c, lo_r;
        write_reg(REG_H_SPACING, ($urandom_range(0, 3) == 0) ? 23'($urandom)
                                                               : 23'($urandom_range(1, 65536)));
        write_reg(REG_V_SPACING, ($urandom_range(0, 3) == 0) ? 23'($urandom)
                                                               : 23'($urandom_range(1, 65536)));
        write_reg(REG_HALF_WIDTH, 23'($urandom));
        write_reg(REG_HALF_HEIGHT, 23'($urandom_range(0, 1000000)));
        lo_c = $urandom_range(0, 20);
        lo_r = $urandom_range(0, 20);
        write_reg(REG_HOLE_COL_LO, lo_c);
        write_reg(REG_HOLE_COL_HI, ($urandom_range(0, 5) == 0) ? lo_c - 1 : lo_c + $urandom_range(1, 12));
        write_reg(REG_HOLE_ROW_LO, lo_r);
        write_reg(REG_HOLE_ROW_HI, lo_r + $urandom_range(0, 12));
        end_writes();
    endtask

    // run limit
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        cell_col <= '0;
        cell_row <= '0;
        height_corner_a <= '0;
        height_corner_b <= '0;
        height_corner_c <= '0;
        height_corner_d <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: flat, extreme heights, corner cells, normal flip
        send_cell(0, 0, 0, 0, 0, 0);
        send_cell(1023, 1023, 24'sh7fffff, -24'sh800000, 24'sh7fffff, -24'sh800000);
        send_cell(5, 7, -24'sh800000, 24'sh7fffff, -24'sh800000, 24'sh7fffff);
        send_cell(0, 1023, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_cell(1023, 0, 24'sh001000, 24'sh002000, 24'sh000000, 24'sh003000);
        send_cell(12, 3, 24'sh400000, -24'sh400000, 24'sh100000, -24'sh000001);
        drain();

        // extreme spacings and offsets, saturated coordinates, hole of one cell
        write_reg(REG_H_SPACING, 23'h7fffff);
        write_reg(REG_V_SPACING, 23'h7fffff);
        write_reg(REG_HALF_WIDTH, 23'h7fffff);
        write_reg(REG_HALF_HEIGHT, 23'h7fffff);
        write_reg(REG_HOLE_COL_LO, 11'd3);
        write_reg(REG_HOLE_COL_HI, 11'd4);
        write_reg(REG_HOLE_ROW_LO, 11'd3);
        write_reg(REG_HOLE_ROW_HI, 11'd4);
        write_reg(REG_SPARE_LO, 23'h000123);
        write_reg(REG_SPARE_HI, 23'h7fffff);
        end_writes();
        send_cell(3, 3, 24'sh001000, 0, 0, 0);
        send_cell(0, 0, 24'sh7fffff, -24'sh800000, 24'sh000000, 24'sh7fffff);
        send_cell(1023, 1023, -24'sh800000, 24'sh7fffff, 24'sh7fffff, -24'sh800000);
        send_cell(4, 3, 24'sh010000, 24'sh020000, 24'sh030000, 24'sh040000);
        send_cell(3, 2, 1, 2, 3, 4);
        drain();

        // zero and minimal spacings: degenerate normals; hole spans every column but no row, so is empty
        write_reg(REG_H_SPACING, 23'd0);
        write_reg(REG_V_SPACING, 23'd1);
        write_reg(REG_HALF_WIDTH, 23'd0);
        write_reg(REG_HALF_HEIGHT, 23'd1);
        write_reg(REG_HOLE_COL_LO, 11'd0);
        write_reg(REG_HOLE_COL_HI, 11'd1024);
        write_reg(REG_HOLE_ROW_LO, 11'd1024);
        write_reg(REG_HOLE_ROW_HI, 11'd1024);
        end_writes();
        send_cell(9, 9, 0, 0, 0, 0);
        send_cell(9, 9, 24'sh001000, 24'sh001000, 24'sh001000, 24'sh001000);
        send_cell(100, 200, 24'sh123456, -24'sh000321, 24'sh000777, 24'sh7fffff);
        drain();
        write_reg(REG_V_SPACING, 23'd0);
        end_writes();
        send_cell(2, 2, 0, 0, 0, 0);
        send_cell(2, 2, 24'sh000010, 0, 24'sh000020, 24'sh000030);
        drain();

        // random phases with changing settings
        repeat (6)
        begin
            random_config();
            random_cells(32, ($urandom_range(0, 1) == 0) ? 24 : 1023);
            drain();
        end
        write_reg(REG_HOLE_ROW_LO, 11'd0);
        write_reg(REG_HOLE_ROW_HI, 11'd1024);
        end_writes();
        random_cells(10, 1023);
        drain();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/hcmn_pkg.sv
design/hcmn_normal.sv
design/hcmn_vbuf.sv
design/heightmap_cell_mesh_normals_unit.sv
verif/heightmap_cell_mesh_normals_unit_tb.sv
